### sv/rmu_pkg.sv
// Shared types and constants for the RMSProp weight update pipeline.
`default_nettype none
package rmu_pkg;

   localparam int unsigned ONE_Q16   = 65536;
   localparam int unsigned QUOT_BITS = 41;

   typedef enum logic [1:0] {
      REG_LEARN_RATE     = 2'd0,
      REG_SQUARE_DECAY   = 2'd1,
      REG_MOMENTUM_DECAY = 2'd2,
      REG_WEIGHT_DECAY   = 2'd3
   } reg_index_type;

   // Side data that rides alongside the root and divide pipelines.
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [32:0] a;
      logic signed [32:0] k;
      logic               gneg;
      logic [31:0]        nms;
      logic               clip;
      logic [63:0]        num;
   } rmu_carry_type;

endpackage
`default_nettype wire

### sv/rmu_front.sv
// Front end: magnitudes, products, rounding and the new mean square.
`default_nettype none
module rmu_front #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic signed [31:0]   weight,
   input  wire logic signed [31:0]   gradient,
   input  wire logic [31:0]          mean_square,
   input  wire logic signed [31:0]   momentum,
   input  wire logic [24:0]          learn_rate,
   input  wire logic [16:0]          square_decay,
   input  wire logic [16:0]          momentum_decay,
   input  wire logic [31:0]          weight_decay,
   output logic                      out_valid,
   output rmu_pkg::rmu_carry_type    out_carry
);
   import rmu_pkg::*;

   localparam int SQ_W    = 64 - FRAC_BITS;
   localparam int HI_W    = SQ_W - 24;
   localparam int SHIFT_N = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;

   logic [16:0] d, e, m;
   assign d = (square_decay > 17'(ONE_Q16)) ? 17'(ONE_Q16) : square_decay;
   assign m = (momentum_decay > 17'(ONE_Q16)) ? 17'(ONE_Q16) : momentum_decay;
   assign e = 17'(ONE_Q16) - d;

   // stage 1: magnitudes
   logic        v1_ff;
   logic [31:0] gm_ff, mm_ff, wm_ff, ms1_ff;
   logic signed [31:0] w1_ff;
   logic        gneg1_ff, mneg1_ff, wneg1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      gm_ff    <= gradient[31] ? (~gradient + 32'd1) : gradient;
      mm_ff    <= momentum[31] ? (~momentum + 32'd1) : momentum;
      wm_ff    <= weight[31] ? (~weight + 32'd1) : weight;
      ms1_ff   <= mean_square;
      w1_ff    <= weight;
      gneg1_ff <= gradient[31];
      mneg1_ff <= momentum[31];
      wneg1_ff <= weight[31];
   end

   // stage 2: products
   logic        v2_ff;
   logic [63:0] gsq_ff, km_ff;
   logic [48:0] pm_ff;
   logic [56:0] lp_ff;
   logic [31:0] ms2_ff;
   logic signed [31:0] w2_ff;
   logic        gneg2_ff, mneg2_ff, wneg2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      gsq_ff   <= 64'(gm_ff) * 64'(gm_ff);
      km_ff    <= 64'(wm_ff) * 64'(weight_decay);
      pm_ff    <= 49'(m) * 49'(mm_ff);
      lp_ff    <= 57'(learn_rate) * 57'(gm_ff);
      ms2_ff   <= ms1_ff;
      w2_ff    <= w1_ff;
      gneg2_ff <= gneg1_ff;
      mneg2_ff <= mneg1_ff;
      wneg2_ff <= wneg1_ff;
   end

   // stage 3: rounding of the products
   logic [63:0] gsq_rnd, km_rnd;
   logic [48:0] pm_rnd;
   logic [32:0] a_mag, k_mag;
   logic [SQ_W-1:0] sq_in;
   rmu_carry_type c3_in;

   always_comb begin
      gsq_rnd = gsq_ff + (64'd1 << (FRAC_BITS - 1));
      sq_in   = SQ_W'(gsq_rnd >> FRAC_BITS);
      pm_rnd  = pm_ff + 49'd32768;
      a_mag   = 33'(pm_rnd >> 16);
      km_rnd  = km_ff + (64'd1 << 31);
      k_mag   = 33'(km_rnd >> 32);
      c3_in.w    = w2_ff;
      c3_in.a    = mneg2_ff ? -$signed(a_mag) : $signed(a_mag);
      c3_in.k    = wneg2_ff ? -$signed(k_mag) : $signed(k_mag);
      c3_in.gneg = gneg2_ff;
      c3_in.nms  = 32'd0;
      c3_in.clip = 1'b0;
      c3_in.num  = 64'(lp_ff) << SHIFT_N;
   end

   logic            v3_ff;
   logic [SQ_W-1:0] sq_ff;
   logic [31:0]     ms3_ff;
   rmu_carry_type   c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      sq_ff  <= sq_in;
      ms3_ff <= ms2_ff;
      c3_ff  <= c3_in;
   end

   // stage 4: decay products, square split in two partial products
   logic          v4_ff;
   logic [48:0]   p0_ff;
   logic [40:0]   p1_ff;
   logic [HI_W+16:0] p2_ff;
   rmu_carry_type c4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      p0_ff <= 49'(d) * 49'(ms3_ff);
      p1_ff <= 41'(e) * 41'(sq_ff[23:0]);
      p2_ff <= (HI_W + 17)'(e) * (HI_W + 17)'(sq_ff[SQ_W-1:24]);
      c4_ff <= c3_ff;
   end

   // stage 5: sum, round, saturate
   logic [65:0] acc;
   logic [49:0] nms_full;
   rmu_carry_type c5_in;

   always_comb begin
      acc = 66'(p0_ff) + 66'(p1_ff) + (66'(p2_ff) << 24) + 66'd32768;
      nms_full = 50'(acc >> 16);
      c5_in = c4_ff;
      if (nms_full > 50'h0_FFFF_FFFF) begin
         c5_in.nms  = 32'hFFFF_FFFF;
         c5_in.clip = 1'b1;
      end else begin
         c5_in.nms  = nms_full[31:0];
      end
   end

   logic          v5_ff;
   rmu_carry_type c5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      c5_ff <= c5_in;
   end

   assign out_valid = v5_ff;
   assign out_carry = c5_ff;

endmodule
`default_nettype wire

### sv/rmu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module rmu_sqrt #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire rmu_pkg::rmu_carry_type in_carry,
   output logic                        out_valid,
   output logic [(33+FRAC_BITS)/2-1:0] out_root,
   output rmu_pkg::rmu_carry_type      out_carry
);
   import rmu_pkg::*;

   localparam int ROOT_W = (33 + FRAC_BITS) / 2;
   localparam int XW     = 2 * ROOT_W;
   localparam int RW     = ROOT_W + 3;

   logic [31:0] s;
   logic [XW-1:0] x_in;
   // one-LSB floor keeps the divisor non-zero
   assign s    = (in_carry.nms == 32'd0) ? 32'd1 : in_carry.nms;
   assign x_in = XW'(s) << FRAC_BITS;

   logic              v_ff    [ROOT_W];
   logic [RW-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [XW-1:0]     x_ff    [ROOT_W];
   rmu_carry_type     c_ff    [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic              v_c;
      logic [RW-1:0]     rem_c, cur, trial;
      logic [ROOT_W-1:0] root_c;
      logic [XW-1:0]     x_c;
      rmu_carry_type     c_c;
      logic              ge;

      if (j == 0) begin : g_first
         assign v_c    = in_valid;
         assign rem_c  = '0;
         assign root_c = '0;
         assign x_c    = x_in;
         assign c_c    = in_carry;
      end else begin : g_next
         assign v_c    = v_ff[j-1];
         assign rem_c  = rem_ff[j-1];
         assign root_c = root_ff[j-1];
         assign x_c    = x_ff[j-1];
         assign c_c    = c_ff[j-1];
      end

      assign cur   = {rem_c[RW-3:0], x_c[XW-1 -: 2]};
      assign trial = RW'({root_c, 2'b01});
      assign ge    = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_c;
         end
         rem_ff[j]  <= ge ? (cur - trial) : cur;
         root_ff[j] <= {root_c[ROOT_W-2:0], ge};
         x_ff[j]    <= x_c << 2;
         c_ff[j]    <= c_c;
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_carry = c_ff[ROOT_W-1];

endmodule
`default_nettype wire

### sv/rmu_div.sv
// Pipelined rounded division of the step numerator by the root.
`default_nettype none
module rmu_div #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [(33+FRAC_BITS)/2-1:0] in_root,
   input  wire rmu_pkg::rmu_carry_type      in_carry,
   output logic                             out_valid,
   output logic [rmu_pkg::QUOT_BITS-1:0]    out_quot,
   output logic                             out_ovf,
   output rmu_pkg::rmu_carry_type           out_carry
);
   import rmu_pkg::*;

   localparam int ROOT_W  = (33 + FRAC_BITS) / 2;
   localparam int SHIFT_D = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
   localparam int DEN_W   = ROOT_W + SHIFT_D;
   localparam int CW      = (DEN_W + 42 > 66) ? DEN_W + 42 : 66;
   localparam int QB      = QUOT_BITS;

   logic [DEN_W-1:0] den_in;
   logic [CW-1:0]    numer;
   logic             ovf_in;

   // half a divisor added up front gives round half up
   assign den_in = DEN_W'(in_root) << SHIFT_D;
   assign numer  = CW'(in_carry.num) + CW'(den_in >> 1);
   assign ovf_in = (numer >= (CW'(den_in) << QB));

   logic             v0_ff, ovf0_ff;
   logic [CW-1:0]    rem0_ff;
   logic [DEN_W-1:0] den0_ff;
   rmu_carry_type    c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      ovf0_ff <= ovf_in;
      rem0_ff <= numer;
      den0_ff <= den_in;
      c0_ff   <= in_carry;
   end

   logic             v_ff   [QB];
   logic             ovf_ff [QB];
   logic [CW-1:0]    rem_ff [QB];
   logic [DEN_W-1:0] den_ff [QB];
   logic [QB-1:0]    q_ff   [QB];
   rmu_carry_type    c_ff   [QB];

   for (genvar j = 0; j < QB; j++) begin : g_stage
      logic             v_c, ovf_c, ge;
      logic [CW-1:0]    rem_c, dsh;
      logic [DEN_W-1:0] den_c;
      logic [QB-1:0]    q_c;
      rmu_carry_type    c_c;

      if (j == 0) begin : g_first
         assign v_c   = v0_ff;
         assign ovf_c = ovf0_ff;
         assign rem_c = rem0_ff;
         assign den_c = den0_ff;
         assign q_c   = '0;
         assign c_c   = c0_ff;
      end else begin : g_next
         assign v_c   = v_ff[j-1];
         assign ovf_c = ovf_ff[j-1];
         assign rem_c = rem_ff[j-1];
         assign den_c = den_ff[j-1];
         assign q_c   = q_ff[j-1];
         assign c_c   = c_ff[j-1];
      end

      assign dsh = CW'(den_c) << (QB - 1 - j);
      assign ge  = (rem_c >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_c;
         end
         ovf_ff[j] <= ovf_c;
         rem_ff[j] <= ge ? (rem_c - dsh) : rem_c;
         den_ff[j] <= den_c;
         q_ff[j]   <= {q_c[QB-2:0], ge};
         c_ff[j]   <= c_c;
      end
   end

   assign out_valid = v_ff[QB-1];
   assign out_quot  = q_ff[QB-1];
   assign out_ovf   = ovf_ff[QB-1];
   assign out_carry = c_ff[QB-1];

endmodule
`default_nettype wire

### sv/rmu_back.sv
// Back end: step clip, momentum and weight sums with saturation.
`default_nettype none
module rmu_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [rmu_pkg::QUOT_BITS-1:0] in_quot,
   input  wire logic                        in_ovf,
   input  wire rmu_pkg::rmu_carry_type      in_carry,
   output logic                             out_valid,
   output logic signed [31:0]               out_new_weight,
   output logic [31:0]                      out_new_mean_square,
   output logic signed [31:0]               out_new_momentum,
   output logic                             out_saturated
);
   import rmu_pkg::*;

   localparam logic [QUOT_BITS-1:0] STEP_CLIP = QUOT_BITS'(1) << (QUOT_BITS - 1);

   // stage 1: new momentum
   logic [QUOT_BITS-1:0] qc;
   logic signed [43:0]   step, mom_raw;
   logic signed [31:0]   nmom_in;
   logic                 clip_m;

   always_comb begin
      qc      = (in_ovf || in_quot > STEP_CLIP) ? STEP_CLIP : in_quot;
      step    = in_carry.gneg ? -$signed(44'(qc)) : $signed(44'(qc));
      mom_raw = 44'(in_carry.a) - step;
      clip_m  = 1'b1;
      if (mom_raw > 44'sd2147483647) begin
         nmom_in = 32'sh7FFF_FFFF;
      end else if (mom_raw < -44'sd2147483648) begin
         nmom_in = 32'sh8000_0000;
      end else begin
         nmom_in = mom_raw[31:0];
         clip_m  = 1'b0;
      end
   end

   logic               v1_ff, clip1_ff;
   logic signed [31:0] nmom_ff, w1_ff;
   logic signed [32:0] k1_ff;
   logic [31:0]        nms1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      clip1_ff <= in_carry.clip | clip_m;
      nmom_ff  <= nmom_in;
      w1_ff    <= in_carry.w;
      k1_ff    <= in_carry.k;
      nms1_ff  <= in_carry.nms;
   end

   // stage 2: new weight
   logic signed [35:0] w_raw;
   logic signed [31:0] nw_in;
   logic               clip_w;

   always_comb begin
      w_raw  = 36'(w1_ff) + 36'(nmom_ff) - 36'(k1_ff);
      clip_w = 1'b1;
      if (w_raw > 36'sd2147483647) begin
         nw_in = 32'sh7FFF_FFFF;
      end else if (w_raw < -36'sd2147483648) begin
         nw_in = 32'sh8000_0000;
      end else begin
         nw_in  = w_raw[31:0];
         clip_w = 1'b0;
      end
   end

   logic               v2_ff, sat_ff;
   logic signed [31:0] nw_ff, nmom2_ff;
   logic [31:0]        nms2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sat_ff   <= clip1_ff | clip_w;
      nw_ff    <= nw_in;
      nmom2_ff <= nmom_ff;
      nms2_ff  <= nms1_ff;
   end

   assign out_valid           = v2_ff;
   assign out_new_weight      = nw_ff;
   assign out_new_mean_square = nms2_ff;
   assign out_new_momentum    = nmom2_ff;
   assign out_saturated       = sat_ff;

endmodule
`default_nettype wire

### sv/rmsprop_momentum_weight_update.sv
// Top level of the RMSProp with momentum weight update pipeline.
//
// Input: a transaction is taken on a rising edge with start high and
// busy low. busy is only high during reset, so one weight can be sent on
// every cycle. Each transaction carries weight, gradient, mean square and
// momentum in signed/unsigned Q(32-F).F.
// Output: exactly one result per transaction, shown for one cycle with
// rsp_valid high, in the order of the inputs. The receiver cannot stall;
// nothing waits on it.
// Pipeline: five front stages for the products and the mean square, one
// stage per root bit of the square root, 42 stages of the one-bit-per-stage
// divider and two for the saturating sums. Throughput is one transaction
// per cycle.
// Configuration: csr_wr_en writes csr_wdata to register csr_index on the
// clock edge; write only while the pipeline is empty.
// Reset: synchronous, clears the pipeline valid bits and restores the
// register defaults; transactions in flight are dropped.
`default_nettype none
module rmsprop_momentum_weight_update #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_weight,
   input  wire logic signed [31:0] req_gradient,
   input  wire logic [31:0]        req_mean_square,
   input  wire logic signed [31:0] req_momentum,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_new_weight,
   output logic [31:0]             rsp_new_mean_square,
   output logic signed [31:0]      rsp_new_momentum,
   output logic                    rsp_saturated,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import rmu_pkg::*;

   localparam int ROOT_W  = (33 + FRAC_BITS) / 2;
   localparam int LATENCY = 5 + ROOT_W + 1 + QUOT_BITS + 2;

   logic [24:0] learn_rate_ff;
   logic [16:0] square_decay_ff, momentum_decay_ff;
   logic [31:0] weight_decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff     <= 25'd167772;
         square_decay_ff   <= 17'd58982;
         momentum_decay_ff <= 17'd0;
         weight_decay_ff   <= 32'd859;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_LEARN_RATE:     learn_rate_ff     <= csr_wdata[24:0];
            REG_SQUARE_DECAY:   square_decay_ff   <= csr_wdata[16:0];
            REG_MOMENTUM_DECAY: momentum_decay_ff <= csr_wdata[16:0];
            REG_WEIGHT_DECAY:   weight_decay_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   logic          f_valid, s_valid, d_valid, d_ovf;
   rmu_carry_type f_carry, s_carry, d_carry;
   logic [ROOT_W-1:0]    s_root;
   logic [QUOT_BITS-1:0] d_quot;

   rmu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .weight         (req_weight),
      .gradient       (req_gradient),
      .mean_square    (req_mean_square),
      .momentum       (req_momentum),
      .learn_rate     (learn_rate_ff),
      .square_decay   (square_decay_ff),
      .momentum_decay (momentum_decay_ff),
      .weight_decay   (weight_decay_ff),
      .out_valid      (f_valid),
      .out_carry      (f_carry)
   );

   rmu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_carry  (f_carry),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_carry (s_carry)
   );

   rmu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_carry  (s_carry),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_ovf   (d_ovf),
      .out_carry (d_carry)
   );

   rmu_back u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (d_valid),
      .in_quot             (d_quot),
      .in_ovf              (d_ovf),
      .in_carry            (d_carry),
      .out_valid           (rsp_valid),
      .out_new_weight      (rsp_new_weight),
      .out_new_mean_square (rsp_new_mean_square),
      .out_new_momentum    (rsp_new_momentum),
      .out_saturated       (rsp_saturated)
   );

   // the result strobe is the accept strobe delayed through every pipeline stage
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept, LATENCY))
      else $error("result strobe does not match accepted transaction");

   // the flag may only be set when some result sits at a range limit
   a_sat_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_new_mean_square == 32'hFFFF_FFFF ||
          rsp_new_momentum == 32'sh7FFF_FFFF || rsp_new_momentum == 32'sh8000_0000 ||
          rsp_new_weight == 32'sh7FFF_FFFF || rsp_new_weight == 32'sh8000_0000))
      else $error("saturated flag without a clipped result");

endmodule
`default_nettype wire

### dv/tb_rmsprop_momentum_weight_update.sv
// Self-checking testbench for the RMSProp momentum weight update pipeline.
`default_nettype none
module tb_rmsprop_momentum_weight_update;
   timeunit 1ns;
   timeprecision 1ps;
   import rmu_pkg::*;

   localparam int F       = 24;
   localparam int LATENCY = 49 + (33 + F) / 2;

   typedef struct packed {
      logic signed [31:0] nw;
      logic [31:0]        nms;
      logic signed [31:0] nmom;
      logic               sat;
   } update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_weight = '0;
   logic signed [31:0] req_gradient = '0;
   logic [31:0]        req_mean_square = '0;
   logic signed [31:0] req_momentum = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_new_weight;
   logic [31:0]        rsp_new_mean_square;
   logic signed [31:0] rsp_new_momentum;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   rmsprop_momentum_weight_update #(.FRAC_BITS(F)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the registers
   logic [24:0] lr_q;
   logic [16:0] sd_q, md_q;
   logic [31:0] wd_q;
   update_type  pending_updates[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int sat_seen = 0;

   function automatic logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref logic c);
      if (v > 64'sd2147483647) begin
         c = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         c = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic update_type rmsprop_update(logic signed [31:0] w,
         logic signed [31:0] g, logic [31:0] ms, logic signed [31:0] mom);
      update_type u;
      logic c;
      logic [63:0] d, m, gm, sq, acc, nms, s, r, num, den, q, pm, km, wm, mm;
      logic signed [63:0] a, stp, nmom, k, nw;
      c   = 1'b0;
      d   = (sd_q > ONE_Q16) ? 64'(ONE_Q16) : 64'(sd_q);
      m   = (md_q > ONE_Q16) ? 64'(ONE_Q16) : 64'(md_q);
      gm  = g < 0 ? 64'(-64'(g)) : 64'(g);
      sq  = (gm * gm + (64'd1 << (F - 1))) >> F;
      acc = d * 64'(ms) + (64'(ONE_Q16) - d) * sq;
      nms = (acc + 64'd32768) >> 16;
      if (nms > 64'hFFFF_FFFF) begin
         nms = 64'hFFFF_FFFF;
         c = 1'b1;
      end
      s   = nms == 0 ? 64'd1 : nms;
      r   = int_root(s << F);
      num = 64'(lr_q) * gm;
      den = r;
      if (F >= 24) num <<= (F - 24);
      else den <<= (24 - F);
      q = (num + (den >> 1)) / den;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      mm  = mom < 0 ? 64'(-64'(mom)) : 64'(mom);
      pm  = m * mm;
      a   = $signed((pm + 64'd32768) >> 16);
      if (mom < 0) a = -a;
      stp = g < 0 ? -$signed(q) : $signed(q);
      nmom = clip32(a - stp, c);
      wm  = w < 0 ? 64'(-64'(w)) : 64'(w);
      km  = (wm * 64'(wd_q) + (64'd1 << 31)) >> 32;
      k   = w < 0 ? -$signed(km) : $signed(km);
      nw  = clip32(64'(w) + nmom - k, c);
      u.nw = nw[31:0];
      u.nms = nms[31:0];
      u.nmom = nmom[31:0];
      u.sat = c;
      return u;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_LEARN_RATE:     lr_q = val[24:0];
         REG_SQUARE_DECAY:   sd_q = val[16:0];
         REG_MOMENTUM_DECAY: md_q = val[16:0];
         default:            wd_q = val;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // start stays high across back-to-back transactions; lowered only on a gap
   task automatic send_update(logic signed [31:0] w, logic signed [31:0] g,
         logic [31:0] ms, logic signed [31:0] mom, bit gaps);
      int gap;
      gap = 0;
      if (gaps && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_weight      <= w;
      req_gradient    <= g;
      req_mean_square <= ms;
      req_momentum    <= mom;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_updates.push_back(rmsprop_update(w, g, ms, mom));
      sent++;
   endtask

   task automatic idle_inputs();
      start <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         update_type e;
         if (pending_updates.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
         end else begin
            e = pending_updates.pop_front();
            checked++;
            if (e.sat) sat_seen++;
            if (rsp_new_weight !== e.nw) begin
               $error("new_weight exp %0d got %0d", e.nw, rsp_new_weight);
               errors++;
            end
            if (rsp_new_mean_square !== e.nms) begin
               $error("new_mean_square exp %0d got %0d", e.nms, rsp_new_mean_square);
               errors++;
            end
            if (rsp_new_momentum !== e.nmom) begin
               $error("new_momentum exp %0d got %0d", e.nmom, rsp_new_momentum);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
         3: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0);
      send_update(32'sh8000_0000, 32'sh8000_0000, 32'h0, 32'sh8000_0000, 0);
      send_update(0, 0, 0, 0, 0);                    // zero mean square floor
      send_update(32'sh0100_0000, 32'sh0000_1000, 0, 32'sh0010_0000, 0);
      send_update(-32'sh0100_0000, -32'sh0000_0001, 0, -32'sh0010_0000, 0);
      send_update(32'sh0100_0000, 32'sh0001_0000, 32'h0100_0000, 0, 0);
      send_update(-1, 1, 1, -1, 0);
      send_update(32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'h0, 32'sh7FFF_FFFF, 0);
      idle_inputs();
      drain();
      // decays above one, learn rate above one, maximum shrink: huge step
      write_reg(REG_SQUARE_DECAY, 32'h1FFFF);
      write_reg(REG_MOMENTUM_DECAY, 32'h1FFFF);
      write_reg(REG_LEARN_RATE, 32'h1FF_FFFF);
      write_reg(REG_WEIGHT_DECAY, 32'hFFFF_FFFF);
      send_update(32'sh4000_0000, 32'sh7FFF_FFFF, 0, 32'sh4000_0000, 0);
      send_update(-32'sh4000_0000, -32'sh0000_0100, 1, -32'sh4000_0000, 0);
      send_update(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 32'sh8000_0000, 0);
      send_update(32'sh0000_0001, 32'sh0000_0001, 32'hFFFF_FFFF, 32'sh0000_0001, 0);
      idle_inputs();
      drain();
      write_reg(REG_SQUARE_DECAY, 0);
      write_reg(REG_MOMENTUM_DECAY, 32'h10000);
      write_reg(REG_LEARN_RATE, 0);
      write_reg(REG_WEIGHT_DECAY, 0);
      send_update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h1234_5678, 32'sh7FFF_FFFF, 0);
      send_update(32'sh8000_0000, 32'sh0800_0000, 32'h0, 32'sh8000_0000, 0);
      idle_inputs();
      drain();
   endtask

   task automatic test_random_settings();
      logic [31:0] v;
      for (int p = 0; p < 6; p++) begin
         v = $urandom();
         write_reg(REG_LEARN_RATE, (p == 0) ? 32'h100_0000 : (p == 1 ? v : v & 32'h3_FFFF));
         v = $urandom();
         write_reg(REG_SQUARE_DECAY, (p == 0) ? 32'h10000 : v);
         v = $urandom();
         write_reg(REG_MOMENTUM_DECAY, (p == 2) ? 32'h0 : v);
         v = $urandom();
         write_reg(REG_WEIGHT_DECAY, (p == 3) ? 32'hFFFF_FFFF : (p > 3 ? v & 32'hFFFF : v));
         for (int i = 0; i < 250; i++)
            send_update(rand_field(), rand_field(), rand_field(), rand_field(), 1);
         idle_inputs();
         drain();
      end
   endtask

   initial begin
      lr_q = 25'd167772;
      sd_q = 17'd58982;
      md_q = 17'd0;
      wd_q = 32'd859;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      repeat (LATENCY + 10) @(posedge clock);
      if (pending_updates.size() != 0) begin
         $error("%0d expected results never arrived", pending_updates.size());
         errors++;
      end
      $display("sent %0d transactions over 9 register settings, checked %0d, %0d saturating",
               sent, checked, sat_seen);
      if (errors == 0)
         $display("tb_rmsprop_momentum_weight_update: clean");
      else
         $display("tb_rmsprop_momentum_weight_update: errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_rmsprop_momentum_weight_update: errors");
      $finish;
   end
endmodule
`default_nettype wire
